// ===== rtl/look_at_view_projection_assert.svh =====
// Assertion macros used by the look-at projection top-level RTL.
`ifndef LOOK_AT_VIEW_PROJECTION_ASSERT_SVH
`define LOOK_AT_VIEW_PROJECTION_ASSERT_SVH
`ifndef ASSERT_OFF
`define LAVP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define LAVP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define LAVP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define LAVP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/lavp_pkg.sv =====
package lavp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int MAG_W         = 64;
  localparam int MSB_W         = 6;
  localparam int NORM_MSB      = 29;
  localparam int SCL_W         = 30;
  localparam int SQR_W         = 60;
  localparam int SUMSQ_W       = 62;
  localparam int ROOT_W        = 32;
  localparam int SQRT_STEPS    = 16;
  localparam int REG_COUNT     = 8;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 64;
  localparam int IN_DATA_W     = 288;
  localparam int OUT_DATA_W    = 40;
  localparam int OUT_USER_W    = 2;
  localparam int ELEM_CNT_W    = 4;

  // tuser bit positions on the result channel
  localparam int USER_DEGEN = 0;
  localparam int USER_SAT   = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COL0_TOP    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL0_BOTTOM = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COL1_TOP    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COL1_BOTTOM = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COL2_TOP    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COL2_BOTTOM = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COL3_TOP    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COL3_BOTTOM = 4'd7;

  typedef logic [MAG_W-1:0] mag_t;

  // sign and magnitude of a 3-vector
  typedef struct packed {
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
  } vec_sm_t;

  // partial state of the square root digit recurrence
  typedef struct packed {
    mag_t s;
    mag_t r;
  } sqrt_st_t;

  function automatic logic [MSB_W-1:0] msb_idx(input mag_t v);
    logic [MSB_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (v[i]) idx = MSB_W'(i);
    end
    return idx;
  endfunction

  function automatic sqrt_st_t sqrt_step(input sqrt_st_t st, input mag_t b);
    sqrt_st_t o;
    o = st;
    if (st.s >= st.r + b) begin
      o.s = st.s - (st.r + b);
      o.r = (st.r >> 1) + b;
    end else begin
      o.r = st.r >> 1;
    end
    return o;
  endfunction

endpackage

// ===== rtl/lavp_norm.sv =====
// Normalize two sign-magnitude vectors side by side: scale, square,
// square root (two digits a cycle), then three divides per vector.
module lavp_norm #(
  parameter int FRACTION_BITS = lavp_pkg::FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  lavp_pkg::vec_sm_t [1:0]                  in_vec,
  input  logic [2:0][lavp_pkg::COORD_W-1:0]        in_pos,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [1:0][2:0][FRACTION_BITS+1:0]       out_unit,
  output logic [1:0]                               out_ok,
  output logic [2:0][lavp_pkg::COORD_W-1:0]        out_pos
);

  localparam int CW         = FRACTION_BITS + 2;
  localparam int QW_P       = 2 * ((FRACTION_BITS + 2) / 2);
  localparam int NUM_W      = FRACTION_BITS + lavp_pkg::SCL_W + 1;
  localparam int DIV_STEPS  = QW_P / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
  localparam int REM_W      = lavp_pkg::ROOT_W + 1;
  localparam int SQ_CNT_W   = $clog2(lavp_pkg::SQRT_STEPS + 1);
  localparam int MW         = lavp_pkg::MSB_W;
  localparam int SW         = lavp_pkg::SCL_W;

  // stage 1: capture vectors and leading-one position
  logic                                    n1_v_r;
  lavp_pkg::vec_sm_t [1:0]                 n1_vec_r;
  logic [1:0][MW-1:0]                      n1_msb_r;
  logic [1:0][MW-1:0]                      n1_msb_nxt;
  logic [1:0]                              n1_ok_r;
  logic [1:0]                              n1_ok_nxt;
  logic [2:0][lavp_pkg::COORD_W-1:0]       n1_pos_r;
  // stage 2: scaled magnitudes
  logic                                    n2_v_r;
  logic [1:0][2:0][SW-1:0]                 n2_a_r;
  logic [1:0][2:0][SW-1:0]                 n2_a_nxt;
  logic [1:0][2:0]                         n2_neg_r;
  logic [1:0]                              n2_ok_r;
  logic [2:0][lavp_pkg::COORD_W-1:0]       n2_pos_r;
  // stage 3: squares
  logic                                    n3_v_r;
  logic [1:0][2:0][lavp_pkg::SQR_W-1:0]    n3_sq_r;
  logic [1:0][2:0][SW-1:0]                 n3_a_r;
  logic [1:0][2:0]                         n3_neg_r;
  logic [1:0]                              n3_ok_r;
  logic [2:0][lavp_pkg::COORD_W-1:0]       n3_pos_r;
  // square root stage
  logic                                    q_v_r;
  logic [SQ_CNT_W-1:0]                     q_cnt_r;
  lavp_pkg::mag_t                          q_bit_r;
  lavp_pkg::sqrt_st_t [1:0]                q_st_r;
  lavp_pkg::sqrt_st_t [1:0]                q_st_nxt;
  logic [1:0][2:0][SW-1:0]                 q_a_r;
  logic [1:0][2:0]                         q_neg_r;
  logic [1:0]                              q_ok_r;
  logic [2:0][lavp_pkg::COORD_W-1:0]       q_pos_r;
  logic                                    q_done;
  logic                                    q_rdy;
  // divide stage
  logic                                    d_v_r;
  logic [DIV_CNT_W-1:0]                    d_cnt_r;
  logic [1:0][2:0][REM_W-1:0]              d_rem_r;
  logic [1:0][2:0][REM_W-1:0]              d_rem_nxt;
  logic [1:0][2:0][QW_P-1:0]               d_nlo_r;
  logic [1:0][2:0][QW_P-1:0]               d_quo_r;
  logic [1:0][2:0][QW_P-1:0]               d_quo_nxt;
  logic [1:0][2:0][REM_W-1:0]              d_rem_ld;
  logic [1:0][2:0][QW_P-1:0]               d_nlo_ld;
  logic [1:0][lavp_pkg::ROOT_W-1:0]        d_len_r;
  logic [1:0][2:0]                         d_neg_r;
  logic [1:0]                              d_ok_r;
  logic [2:0][lavp_pkg::COORD_W-1:0]       d_pos_r;
  logic                                    d_done;
  logic                                    d_rdy;
  logic                                    n1_rdy;
  logic                                    n2_rdy;
  logic                                    n3_rdy;

  // elastic handshake through the stages
  assign d_done   = (d_cnt_r == DIV_CNT_W'(DIV_STEPS));
  assign d_rdy    = !d_v_r || (d_done && out_ready);
  assign q_done   = (q_cnt_r == SQ_CNT_W'(lavp_pkg::SQRT_STEPS));
  assign q_rdy    = !q_v_r || (q_done && d_rdy);
  assign n3_rdy   = !n3_v_r || q_rdy;
  assign n2_rdy   = !n2_v_r || n3_rdy;
  assign n1_rdy   = !n1_v_r || n2_rdy;
  assign in_ready = n1_rdy;

  // find leading one of the largest magnitude
  always_comb begin
    for (int v = 0; v < 2; v++) begin
      n1_msb_nxt[v] = lavp_pkg::msb_idx(in_vec[v].mag[0] | in_vec[v].mag[1] |
                                        in_vec[v].mag[2]);
      n1_ok_nxt[v]  = |(in_vec[v].mag[0] | in_vec[v].mag[1] | in_vec[v].mag[2]);
    end
  end

  // scale so the largest magnitude lands in [2^29, 2^30)
  always_comb begin
    for (int v = 0; v < 2; v++) begin
      for (int i = 0; i < 3; i++) begin
        if (n1_msb_r[v] > MW'(lavp_pkg::NORM_MSB)) begin
          n2_a_nxt[v][i] = SW'(n1_vec_r[v].mag[i] >> (n1_msb_r[v] - MW'(lavp_pkg::NORM_MSB)));
        end else begin
          n2_a_nxt[v][i] = SW'(n1_vec_r[v].mag[i] << (MW'(lavp_pkg::NORM_MSB) - n1_msb_r[v]));
        end
      end
    end
  end

  // two root digits per cycle
  always_comb begin
    for (int v = 0; v < 2; v++) begin
      q_st_nxt[v] = lavp_pkg::sqrt_step(lavp_pkg::sqrt_step(q_st_r[v], q_bit_r),
                                        q_bit_r >> 2);
    end
  end

  // divide operands and two quotient bits per cycle
  always_comb begin
    logic [NUM_W-1:0] num;
    logic [REM_W-1:0] rem;
    logic [QW_P-1:0]  nlo;
    logic [QW_P-1:0]  quo;
    for (int v = 0; v < 2; v++) begin
      for (int i = 0; i < 3; i++) begin
        num = (NUM_W'(q_a_r[v][i]) << FRACTION_BITS) +
              NUM_W'(q_st_r[v].r[lavp_pkg::ROOT_W-1:0] >> 1);
        d_rem_ld[v][i] = REM_W'(num >> QW_P);
        d_nlo_ld[v][i] = num[QW_P-1:0];
        rem = d_rem_r[v][i];
        nlo = d_nlo_r[v][i];
        quo = d_quo_r[v][i];
        for (int s = 0; s < 2; s++) begin
          rem = {rem[REM_W-2:0], nlo[QW_P-1]};
          nlo = nlo << 1;
          quo = quo << 1;
          if (rem >= REM_W'(d_len_r[v])) begin
            rem    = rem - REM_W'(d_len_r[v]);
            quo[0] = 1'b1;
          end
        end
        d_rem_nxt[v][i] = rem;
        d_quo_nxt[v][i] = quo;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n1_v_r  <= 1'b0;
      n2_v_r  <= 1'b0;
      n3_v_r  <= 1'b0;
      q_v_r   <= 1'b0;
      q_cnt_r <= '0;
      d_v_r   <= 1'b0;
      d_cnt_r <= '0;
    end else begin
      if (n1_rdy) n1_v_r <= in_valid;
      if (n2_rdy) n2_v_r <= n1_v_r;
      if (n3_rdy) n3_v_r <= n2_v_r;
      if (q_rdy) begin
        q_v_r   <= n3_v_r;
        q_cnt_r <= '0;
      end else if (q_v_r && !q_done) begin
        q_cnt_r <= q_cnt_r + 1'b1;
      end
      if (d_rdy) begin
        d_v_r   <= q_v_r && q_done;
        d_cnt_r <= '0;
      end else if (d_v_r && !d_done) begin
        d_cnt_r <= d_cnt_r + 1'b1;
      end
    end
  end

  // data registers
  always_ff @(posedge clk) begin
    if (n1_rdy && in_valid) begin
      n1_vec_r <= in_vec;
      n1_msb_r <= n1_msb_nxt;
      n1_ok_r  <= n1_ok_nxt;
      n1_pos_r <= in_pos;
    end
    if (n2_rdy && n1_v_r) begin
      n2_a_r   <= n2_a_nxt;
      n2_neg_r <= {n1_vec_r[1].neg, n1_vec_r[0].neg};
      n2_ok_r  <= n1_ok_r;
      n2_pos_r <= n1_pos_r;
    end
    if (n3_rdy && n2_v_r) begin
      for (int v = 0; v < 2; v++) begin
        for (int i = 0; i < 3; i++) begin
          n3_sq_r[v][i] <= n2_a_r[v][i] * n2_a_r[v][i];
        end
      end
      n3_a_r   <= n2_a_r;
      n3_neg_r <= n2_neg_r;
      n3_ok_r  <= n2_ok_r;
      n3_pos_r <= n2_pos_r;
    end
    if (q_rdy && n3_v_r) begin
      for (int v = 0; v < 2; v++) begin
        q_st_r[v].s <= lavp_pkg::MAG_W'(n3_sq_r[v][0]) + lavp_pkg::MAG_W'(n3_sq_r[v][1]) +
                       lavp_pkg::MAG_W'(n3_sq_r[v][2]);
        q_st_r[v].r <= '0;
      end
      q_bit_r  <= lavp_pkg::mag_t'(1) << (lavp_pkg::SUMSQ_W + 0);
      q_a_r    <= n3_a_r;
      q_neg_r  <= n3_neg_r;
      q_ok_r   <= n3_ok_r;
      q_pos_r  <= n3_pos_r;
    end else if (q_v_r && !q_done) begin
      q_st_r  <= q_st_nxt;
      q_bit_r <= q_bit_r >> 4;
    end
    if (d_rdy && q_v_r && q_done) begin
      d_rem_r <= d_rem_ld;
      d_nlo_r <= d_nlo_ld;
      d_quo_r <= '0;
      for (int v = 0; v < 2; v++) begin
        d_len_r[v] <= q_st_r[v].r[lavp_pkg::ROOT_W-1:0];
      end
      d_neg_r <= q_neg_r;
      d_ok_r  <= q_ok_r;
      d_pos_r <= q_pos_r;
    end else if (d_v_r && !d_done) begin
      d_rem_r <= d_rem_nxt;
      d_quo_r <= d_quo_nxt;
      for (int v = 0; v < 2; v++) begin
        for (int i = 0; i < 3; i++) begin
          d_nlo_r[v][i] <= d_nlo_r[v][i] << 2;
        end
      end
    end
  end

  // reapply signs
  always_comb begin
    for (int v = 0; v < 2; v++) begin
      for (int i = 0; i < 3; i++) begin
        out_unit[v][i] = d_neg_r[v][i] ? (CW'(0) - CW'(d_quo_r[v][i])) : CW'(d_quo_r[v][i]);
      end
    end
  end

  assign out_valid = d_v_r && d_done;
  assign out_ok    = d_ok_r;
  assign out_pos   = d_pos_r;

endmodule

// ===== rtl/look_at_view_projection.sv =====
// Channel | Dir | Payload
// in_     | in  | camera pose: position, facing and up, nine signed coords
// out_    | out | one element of projection x view per beat, 16 per pose
// cfg_    | in  | projection columns, one 64-bit word per write
//
// A pose yields 16 results, one per cycle while the receiver is ready, but
// the square root stage holds each pose through its digit steps and the
// hand-off before it takes the next, so it limits how often a new pose is
// taken; the 16-element emitter is never the bottleneck. The square root and
// the divides dominate the time from a pose to its first result.
// Reset is synchronous and leaves the projection at identity; no clearing pass.
// A stall on the result side backs up through every stage; nothing is dropped or repeated.
`include "look_at_view_projection_assert.svh"
module look_at_view_projection #(
  parameter int FRACTION_BITS = lavp_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // position_x, position_y, position_z, facing_x, facing_y, facing_z,
  // up_x, up_y, up_z (lowest bit first)
  input  logic [lavp_pkg::IN_DATA_W-1:0]        in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // element_row, element_col, element_value, zero pad (lowest bit first)
  output logic [lavp_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                  out_tlast,
  // degenerate, saturated (lowest bit first)
  output logic [lavp_pkg::OUT_USER_W-1:0]       out_tuser,
  input  logic                                  cfg_we,
  input  logic [lavp_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  logic [lavp_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int XW    = lavp_pkg::COORD_W;
  localparam int CW    = FRACTION_BITS + 2;
  localparam int YP_W  = 2 * CW;
  localparam int TP_W  = CW + XW;
  localparam int TS_W  = TP_W + 3;
  localparam int TR_W  = TS_W - FRACTION_BITS;
  localparam int EP_W  = XW + TR_W;
  localparam int ES_W  = EP_W + 2;
  localparam int ECW   = lavp_pkg::ELEM_CNT_W;
  localparam logic [63:0] ONE64 = 64'd1 << FRACTION_BITS;
  localparam logic [63:0] HALF64 = 64'd1 << (FRACTION_BITS - 1);

  // projection registers
  logic [lavp_pkg::CFG_DATA_W-1:0] cfg_r [lavp_pkg::REG_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lavp_pkg::REG_COUNT; i++) begin
        case (lavp_pkg::CFG_IDX_W'(i))
          lavp_pkg::REG_COL0_TOP, lavp_pkg::REG_COL2_BOTTOM: cfg_r[i] <= ONE64;
          lavp_pkg::REG_COL1_TOP, lavp_pkg::REG_COL3_BOTTOM: cfg_r[i] <= ONE64 << 32;
          default: cfg_r[i] <= '0;
        endcase
      end
    end else if (cfg_we && (cfg_idx < lavp_pkg::CFG_IDX_W'(lavp_pkg::REG_COUNT))) begin
      cfg_r[cfg_idx[2:0]] <= cfg_wdata;
    end
  end

  // unpack request fields
  logic signed [XW-1:0] i_pos [3];
  logic signed [XW-1:0] i_fac [3];
  logic signed [XW-1:0] i_up  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      i_pos[i] = in_tdata[XW*i +: XW];
      i_fac[i] = in_tdata[XW*(3+i) +: XW];
      i_up[i]  = in_tdata[XW*(6+i) +: XW];
    end
  end

  // stage A: cross-product terms and facing sign/magnitude
  logic                        a_v_r;
  logic signed [63:0]          a_cr_r [6];
  logic [2:0]                  a_zneg_r;
  lavp_pkg::mag_t              a_zmag_r [3];
  logic [2:0][XW-1:0]          a_pos_r;
  logic                        a_rdy;
  // stage B: normalizer operands
  logic                        b_v_r;
  lavp_pkg::vec_sm_t [1:0]     b_vec_r;
  lavp_pkg::vec_sm_t           b_x_nxt;
  logic [2:0][XW-1:0]          b_pos_r;
  logic                        b_rdy;
  // normalizer
  logic                        nm_in_rdy;
  logic                        nm_out_v;
  logic [1:0][2:0][CW-1:0]     nm_unit;
  logic [1:0]                  nm_ok;
  logic [2:0][XW-1:0]          nm_pos;
  // stage T1: y and translation products
  logic                        t1_v_r;
  logic signed [CW-1:0]        t1_x_r [3];
  logic signed [CW-1:0]        t1_z_r [3];
  logic signed [XW-1:0]        t1_pos_r [3];
  logic                        t1_dg_r;
  logic signed [YP_W-1:0]      t1_yp_r [6];
  logic signed [TP_W-1:0]      t1_xp_r [3];
  logic signed [TP_W-1:0]      t1_zp_r [3];
  logic                        t1_rdy;
  // stage T2: y and two translations
  logic                        t2_v_r;
  logic signed [CW-1:0]        t2_x_r [3];
  logic signed [CW-1:0]        t2_y_r [3];
  logic signed [CW-1:0]        t2_z_r [3];
  logic signed [XW-1:0]        t2_pos_r [3];
  logic                        t2_dg_r;
  logic signed [TR_W-1:0]      t2_tx_r;
  logic signed [TR_W-1:0]      t2_tz_r;
  logic signed [CW-1:0]        t2_y_nxt [3];
  logic signed [TR_W-1:0]      t2_tx_nxt;
  logic signed [TR_W-1:0]      t2_tz_nxt;
  logic                        t2_rdy;
  // stage T3: y dot position products
  logic                        t3_v_r;
  logic signed [CW-1:0]        t3_x_r [3];
  logic signed [CW-1:0]        t3_y_r [3];
  logic signed [CW-1:0]        t3_z_r [3];
  logic                        t3_dg_r;
  logic signed [TR_W-1:0]      t3_tx_r;
  logic signed [TR_W-1:0]      t3_tz_r;
  logic signed [TP_W-1:0]      t3_yp_r [3];
  logic signed [TR_W-1:0]      t3_ty_nxt;
  logic                        t3_rdy;
  // view matrix slot, held while its 16 elements go out
  logic                        s_v_r;
  logic signed [CW-1:0]        s_x_r [3];
  logic signed [CW-1:0]        s_y_r [3];
  logic signed [CW-1:0]        s_z_r [3];
  logic signed [TR_W-1:0]      s_t_r [3];
  logic                        s_dg_r;
  logic                        s_rdy;
  logic [ECW-1:0]              emit_cnt_r;
  // emitter
  logic                        adv;
  logic                        e1_v_r;
  logic signed [EP_W-1:0]      e1_prod_r [4];
  logic [1:0]                  e1_row_r;
  logic [1:0]                  e1_col_r;
  logic                        e1_last_r;
  logic                        e1_dg_r;
  logic signed [TR_W-1:0]      e_vcol [4];
  logic signed [XW-1:0]        e_prow [4];
  logic [1:0]                  e_row;
  logic [1:0]                  e_col;
  logic signed [ES_W-1:0]      o_val;
  logic                        o_sat;
  logic [XW-1:0]               o_clip;
  logic                        out_v_r;
  logic [lavp_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                        out_last_r;
  logic [lavp_pkg::OUT_USER_W-1:0] out_user_r;

  // stall chain, back to front
  assign adv    = !out_v_r || out_tready;
  assign s_rdy  = !s_v_r || (adv && (emit_cnt_r == {ECW{1'b1}}));
  assign t3_rdy = !t3_v_r || s_rdy;
  assign t2_rdy = !t2_v_r || t3_rdy;
  assign t1_rdy = !t1_v_r || t2_rdy;
  assign b_rdy  = !b_v_r || nm_in_rdy;
  assign a_rdy  = !a_v_r || b_rdy;
  assign in_tready = a_rdy;

  // up cross (-facing) as sign and magnitude
  always_comb begin
    logic signed [64:0] d;
    for (int i = 0; i < 3; i++) begin
      d = 65'(a_cr_r[2*i]) - 65'(a_cr_r[2*i+1]);
      b_x_nxt.neg[i] = d[64];
      b_x_nxt.mag[i] = d[64] ? 64'(-d) : 64'(d);
    end
  end

  lavp_norm #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (b_v_r),
    .in_ready  (nm_in_rdy),
    .in_vec    (b_vec_r),
    .in_pos    (b_pos_r),
    .out_valid (nm_out_v),
    .out_ready (t1_rdy),
    .out_unit  (nm_unit),
    .out_ok    (nm_ok),
    .out_pos   (nm_pos)
  );

  // round y and negated translations
  always_comb begin
    logic signed [YP_W:0]   yd;
    logic signed [TS_W-1:0] sx;
    logic signed [TS_W-1:0] sz;
    for (int i = 0; i < 3; i++) begin
      yd = (YP_W+1)'(t1_yp_r[2*i]) - (YP_W+1)'(t1_yp_r[2*i+1]);
      t2_y_nxt[i] = CW'((yd + (YP_W+1)'(HALF64)) >>> FRACTION_BITS);
    end
    sx = -(TS_W'(t1_xp_r[0]) + TS_W'(t1_xp_r[1]) + TS_W'(t1_xp_r[2]));
    sz = -(TS_W'(t1_zp_r[0]) + TS_W'(t1_zp_r[1]) + TS_W'(t1_zp_r[2]));
    t2_tx_nxt = TR_W'((sx + TS_W'(HALF64)) >>> FRACTION_BITS);
    t2_tz_nxt = TR_W'((sz + TS_W'(HALF64)) >>> FRACTION_BITS);
  end

  always_comb begin
    logic signed [TS_W-1:0] sy;
    sy = -(TS_W'(t3_yp_r[0]) + TS_W'(t3_yp_r[1]) + TS_W'(t3_yp_r[2]));
    t3_ty_nxt = TR_W'((sy + TS_W'(HALF64)) >>> FRACTION_BITS);
  end

  // select view column and projection row for the current element
  assign e_row = emit_cnt_r[1:0];
  assign e_col = emit_cnt_r[3:2];

  always_comb begin
    logic [lavp_pkg::CFG_DATA_W-1:0] w;
    for (int k = 0; k < 4; k++) begin
      w = cfg_r[{2'(k), e_row[1]}];
      e_prow[k] = e_row[0] ? w[63:32] : w[31:0];
    end
    if (e_col == 2'd3) begin
      for (int k = 0; k < 3; k++) e_vcol[k] = s_t_r[k];
      e_vcol[3] = TR_W'(ONE64);
    end else begin
      e_vcol[0] = TR_W'(s_x_r[e_col]);
      e_vcol[1] = TR_W'(s_y_r[e_col]);
      e_vcol[2] = TR_W'(s_z_r[e_col]);
      e_vcol[3] = '0;
    end
  end

  // sum, round and clip
  always_comb begin
    logic signed [ES_W-1:0] sum;
    sum = ES_W'(e1_prod_r[0]) + ES_W'(e1_prod_r[1]) + ES_W'(e1_prod_r[2]) +
          ES_W'(e1_prod_r[3]);
    o_val  = (sum + $signed(ES_W'(HALF64))) >>> FRACTION_BITS;
    o_sat  = !((&o_val[ES_W-1:XW-1]) || !(|o_val[ES_W-1:XW-1]));
    o_clip = o_val[ES_W-1] ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}};
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r      <= 1'b0;
      b_v_r      <= 1'b0;
      t1_v_r     <= 1'b0;
      t2_v_r     <= 1'b0;
      t3_v_r     <= 1'b0;
      s_v_r      <= 1'b0;
      emit_cnt_r <= '0;
      e1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (a_rdy)  a_v_r  <= in_tvalid;
      if (b_rdy)  b_v_r  <= a_v_r;
      if (t1_rdy) t1_v_r <= nm_out_v;
      if (t2_rdy) t2_v_r <= t1_v_r;
      if (t3_rdy) t3_v_r <= t2_v_r;
      if (s_rdy)  s_v_r  <= t3_v_r;
      if (adv && s_v_r) emit_cnt_r <= emit_cnt_r + 1'b1;
      if (adv) begin
        e1_v_r  <= s_v_r;
        out_v_r <= e1_v_r;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (a_rdy && in_tvalid) begin
      a_cr_r[0] <= i_up[2] * i_fac[1];
      a_cr_r[1] <= i_up[1] * i_fac[2];
      a_cr_r[2] <= i_up[0] * i_fac[2];
      a_cr_r[3] <= i_up[2] * i_fac[0];
      a_cr_r[4] <= i_up[1] * i_fac[0];
      a_cr_r[5] <= i_up[0] * i_fac[1];
      for (int i = 0; i < 3; i++) begin
        a_zneg_r[i] <= (i_fac[i] > 0);
        a_zmag_r[i] <= i_fac[i][XW-1] ? 64'(-64'(i_fac[i])) : 64'(64'(i_fac[i]));
        a_pos_r[i]  <= i_pos[i];
      end
    end
    if (b_rdy && a_v_r) begin
      b_vec_r[0].neg <= a_zneg_r;
      for (int i = 0; i < 3; i++) b_vec_r[0].mag[i] <= a_zmag_r[i];
      b_vec_r[1] <= b_x_nxt;
      b_pos_r    <= a_pos_r;
    end
    if (t1_rdy && nm_out_v) begin
      for (int i = 0; i < 3; i++) begin
        t1_z_r[i]   <= $signed(nm_unit[0][i]);
        t1_x_r[i]   <= $signed(nm_unit[1][i]);
        t1_pos_r[i] <= $signed(nm_pos[i]);
        t1_xp_r[i]  <= $signed(nm_unit[1][i]) * $signed(nm_pos[i]);
        t1_zp_r[i]  <= $signed(nm_unit[0][i]) * $signed(nm_pos[i]);
      end
      t1_yp_r[0] <= $signed(nm_unit[0][1]) * $signed(nm_unit[1][2]);
      t1_yp_r[1] <= $signed(nm_unit[0][2]) * $signed(nm_unit[1][1]);
      t1_yp_r[2] <= $signed(nm_unit[0][2]) * $signed(nm_unit[1][0]);
      t1_yp_r[3] <= $signed(nm_unit[0][0]) * $signed(nm_unit[1][2]);
      t1_yp_r[4] <= $signed(nm_unit[0][0]) * $signed(nm_unit[1][1]);
      t1_yp_r[5] <= $signed(nm_unit[0][1]) * $signed(nm_unit[1][0]);
      t1_dg_r    <= !(nm_ok[0] && nm_ok[1]);
    end
    if (t2_rdy && t1_v_r) begin
      t2_x_r   <= t1_x_r;
      t2_z_r   <= t1_z_r;
      t2_y_r   <= t2_y_nxt;
      t2_pos_r <= t1_pos_r;
      t2_tx_r  <= t2_tx_nxt;
      t2_tz_r  <= t2_tz_nxt;
      t2_dg_r  <= t1_dg_r;
    end
    if (t3_rdy && t2_v_r) begin
      t3_x_r  <= t2_x_r;
      t3_y_r  <= t2_y_r;
      t3_z_r  <= t2_z_r;
      for (int i = 0; i < 3; i++) t3_yp_r[i] <= t2_y_r[i] * t2_pos_r[i];
      t3_tx_r <= t2_tx_r;
      t3_tz_r <= t2_tz_r;
      t3_dg_r <= t2_dg_r;
    end
    if (s_rdy && t3_v_r) begin
      s_x_r  <= t3_x_r;
      s_y_r  <= t3_y_r;
      s_z_r  <= t3_z_r;
      s_t_r[0] <= t3_tx_r;
      s_t_r[1] <= t3_ty_nxt;
      s_t_r[2] <= t3_tz_r;
      s_dg_r <= t3_dg_r;
    end
    if (adv && s_v_r) begin
      for (int k = 0; k < 4; k++) e1_prod_r[k] <= e_prow[k] * e_vcol[k];
      e1_row_r  <= e_row;
      e1_col_r  <= e_col;
      e1_last_r <= (emit_cnt_r == {ECW{1'b1}});
      e1_dg_r   <= s_dg_r;
    end
    if (adv && e1_v_r) begin
      out_last_r <= e1_last_r;
      if (e1_dg_r) begin
        out_data_r <= {4'b0, {XW{1'b0}}, e1_col_r, e1_row_r};
        out_user_r[lavp_pkg::USER_DEGEN] <= 1'b1;
        out_user_r[lavp_pkg::USER_SAT]   <= 1'b0;
      end else begin
        out_data_r <= {4'b0, (o_sat ? o_clip : o_val[XW-1:0]), e1_col_r, e1_row_r};
        out_user_r[lavp_pkg::USER_DEGEN] <= 1'b0;
        out_user_r[lavp_pkg::USER_SAT]   <= o_sat;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  `LAVP_ASSERT_IMPLY(a_last_corner, clk, rst_n, out_tvalid && out_tlast, out_tdata[3:0] == 4'hF)
  `LAVP_ASSERT_IMPLY(a_degen_zero, clk, rst_n, out_tvalid && out_tuser[lavp_pkg::USER_DEGEN], out_tdata[35:4] == 32'd0 && !out_tuser[lavp_pkg::USER_SAT])
  `LAVP_ASSERT_IMPLY(a_cnt_idle, clk, rst_n, !s_v_r, emit_cnt_r == '0)
  `LAVP_ASSERT_NEXT(a_slot_wrap, clk, rst_n, s_v_r && adv && emit_cnt_r == 4'hF, e1_last_r)

endmodule

// ===== tb/tb_look_at_view_projection.sv =====
`timescale 1ns / 1ps

module tb_look_at_view_projection;
  import lavp_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int DRAIN_CYCLES = 80;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  // position_x/y/z, facing_x/y/z, up_x/y/z (lowest bit first)
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  // element_row, element_col, element_value, zero pad (lowest bit first)
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  // degenerate, saturated (lowest bit first)
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  look_at_view_projection u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  typedef struct {
    logic [1:0]  row;
    logic [1:0]  col;
    logic [31:0] value;
    logic        last;
    logic        degen;
    logic        sat;
  } element_t;

  // Fixed-point look-at model plus the queue of elements still owed by the block
  class matrix_scoreboard;
    logic [CFG_DATA_W-1:0] proj [REG_COUNT];
    element_t owed [$];
    longint   unit_out [3];
    int       fails;

    function new();
      fails = 0;
      foreach (proj[i]) proj[i] = '0;
      proj[REG_COL0_TOP]    = 64'(1) << FB;
      proj[REG_COL1_TOP]    = 64'(1) << (32 + FB);
      proj[REG_COL2_BOTTOM] = 64'(1) << FB;
      proj[REG_COL3_BOTTOM] = 64'(1) << (32 + FB);
    endfunction

    function void write_reg(int idx, logic [CFG_DATA_W-1:0] v);
      if (idx < REG_COUNT) proj[idx] = v;
    endfunction

    function logic [63:0] int_root(logic [63:0] s);
      logic [63:0] r, b;
      r = 0;
      b = 64'(1) << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
        if (s >= r + b) begin
          s = s - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // scale largest magnitude into [2^29, 2^30), then divide by the root
    function bit normalize(logic [2:0] neg, logic [2:0][63:0] mag);
      logic [63:0] a [3];
      logic [63:0] m, s, len, c;
      m = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
        a[i] = mag[i];
        if (a[i] > m) m = a[i];
      end
      if (m == 0) return 0;
      while (m >= (64'(1) << 30)) begin
        for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
        m = m >> 1;
      end
      while (m < (64'(1) << 29)) begin
        for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
        m = m << 1;
      end
      for (int i = 0; i < 3; i++) s = s + a[i] * a[i];
      len = int_root(s);
      for (int i = 0; i < 3; i++) begin
        c = ((a[i] << FB) + len / 2) / len;
        unit_out[i] = neg[i] ? -longint'(c) : longint'(c);
      end
      return 1;
    endfunction

    function longint round_fix(longint v);
      return (v + (longint'(1) << (FB - 1))) >>> FB;
    endfunction

    // note an accepted pose and queue its sixteen elements
    function void note_pose(logic [IN_DATA_W-1:0] d);
      longint pos [3], fac [3], up [3], zv [3], xv [3], yv [3];
      longint vm [4][4], pm [4][4], p, q;
      logic [2:0] neg;
      logic [2:0][63:0] mag;
      logic signed [127:0] acc, pp, vv, val;
      element_t e;
      bit degen;
      for (int i = 0; i < 3; i++) begin
        pos[i] = longint'($signed(d[32*i +: 32]));
        fac[i] = longint'($signed(d[32*(3+i) +: 32]));
        up[i]  = longint'($signed(d[32*(6+i) +: 32]));
      end
      for (int i = 0; i < 3; i++) begin
        neg[i] = fac[i] > 0;
        mag[i] = (fac[i] < 0) ? 64'(-fac[i]) : 64'(fac[i]);
      end
      degen = !normalize(neg, mag);
      if (!degen) begin
        zv = unit_out;
        // exact up x (-facing)
        for (int i = 0; i < 3; i++) begin
          p = up[(i+2)%3] * fac[(i+1)%3];
          q = up[(i+1)%3] * fac[(i+2)%3];
          neg[i] = !(p >= q);
          mag[i] = (p >= q) ? 64'(p) - 64'(q) : 64'(q) - 64'(p);
        end
        degen = !normalize(neg, mag);
        xv = unit_out;
      end
      if (degen) begin
        for (int k = 0; k < 16; k++) begin
          e.row = 2'(k & 3); e.col = 2'(k >> 2); e.value = '0;
          e.last = (k == 15); e.degen = 1; e.sat = 0;
          owed.push_back(e);
        end
        return;
      end
      yv[0] = round_fix(zv[1] * xv[2] - zv[2] * xv[1]);
      yv[1] = round_fix(zv[2] * xv[0] - zv[0] * xv[2]);
      yv[2] = round_fix(zv[0] * xv[1] - zv[1] * xv[0]);
      for (int c = 0; c < 3; c++) begin
        vm[c][0] = xv[c]; vm[c][1] = yv[c]; vm[c][2] = zv[c]; vm[c][3] = 0;
      end
      vm[3][0] = round_fix(-(xv[0] * pos[0] + xv[1] * pos[1] + xv[2] * pos[2]));
      vm[3][1] = round_fix(-(yv[0] * pos[0] + yv[1] * pos[1] + yv[2] * pos[2]));
      vm[3][2] = round_fix(-(zv[0] * pos[0] + zv[1] * pos[1] + zv[2] * pos[2]));
      vm[3][3] = longint'(1) << FB;
      for (int c = 0; c < 4; c++) begin
        pm[c][0] = longint'($signed(proj[2*c][31:0]));
        pm[c][1] = longint'($signed(proj[2*c][63:32]));
        pm[c][2] = longint'($signed(proj[2*c+1][31:0]));
        pm[c][3] = longint'($signed(proj[2*c+1][63:32]));
      end
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          acc = 0;
          for (int k = 0; k < 4; k++) begin
            pp = pm[k][r];
            vv = vm[c][k];
            acc = acc + pp * vv;
          end
          val = (acc + (128'sd1 <<< (FB - 1))) >>> FB;
          e.sat = 0;
          if (val > 128'sd2147483647) begin
            val = 128'sd2147483647; e.sat = 1;
          end else if (val < -128'sd2147483648) begin
            val = -128'sd2147483648; e.sat = 1;
          end
          e.row = 2'(r); e.col = 2'(c); e.value = val[31:0];
          e.last = (c == 3 && r == 3); e.degen = 0;
          owed.push_back(e);
        end
      end
    endfunction

    // compare one accepted element against the oldest owed one
    function void check_element(logic [OUT_DATA_W-1:0] data, logic last,
                                logic [OUT_USER_W-1:0] user);
      element_t e;
      if (owed.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected element data=%h", data);
        return;
      end
      e = owed.pop_front();
      if (data[1:0] !== e.row || data[3:2] !== e.col || data[35:4] !== e.value ||
          data[OUT_DATA_W-1:36] !== '0 || last !== e.last ||
          user[USER_DEGEN] !== e.degen || user[USER_SAT] !== e.sat) begin
        fails++;
        if (fails <= 10)
          $display("mismatch exp r%0d c%0d v=%h last=%b dg=%b sat=%b | got r%0d c%0d v=%h last=%b dg=%b sat=%b",
                   e.row, e.col, e.value, e.last, e.degen, e.sat,
                   data[1:0], data[3:2], data[35:4], last, user[USER_DEGEN], user[USER_SAT]);
      end
    endfunction
  endclass

  matrix_scoreboard sb = new();

  int   gap_pct;
  int   stall_pct;
  logic hold_req;
  int   hold_cnt;
  bit   hold_seen;

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_cnt   <= 0;
      hold_seen  <= 1'b0;
    end else if (hold_req && !hold_seen) begin
      hold_cnt   <= 400;
      hold_seen  <= 1'b1;
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt   <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // check every accepted element
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_element(out_tdata, out_tlast, out_tuser);
  end

  task automatic send_pose(input logic [IN_DATA_W-1:0] d);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    sb.note_pose(d);
  endtask

  // hold the sender until every owed element has come, then let the pipe settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.owed.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_projection(input logic [CFG_DATA_W-1:0] v [REG_COUNT]);
    for (int i = REG_COL0_TOP; i <= REG_COL3_BOTTOM; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= CFG_IDX_W'(i);
      cfg_wdata <= v[i];
      @(posedge clk);
      sb.write_reg(i, v[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [IN_DATA_W-1:0] pack_pose(
      int px, int py, int pz, int fx, int fy, int fz, int ux, int uy, int uz);
    return {ux, uy, uz, fx, fy, fz, px, py, pz} == 0 ? '0 :
           {32'(uz), 32'(uy), 32'(ux), 32'(fz), 32'(fy), 32'(fx),
            32'(pz), 32'(py), 32'(px)};
  endfunction

  function automatic int rand_signed(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // mostly moderate poses, some fully random words, some degenerate
  function automatic logic [IN_DATA_W-1:0] random_pose();
    int kind, fx, fy, fz;
    logic [IN_DATA_W-1:0] d;
    kind = $urandom_range(9);
    fx = rand_signed(1 << 18); fy = rand_signed(1 << 18); fz = rand_signed(1 << 18);
    if (kind == 0)
      d = pack_pose(rand_signed(1 << 20), rand_signed(1 << 20), rand_signed(1 << 20),
                    fx, fy, fz, -fx, -fy, -fz);
    else if (kind == 1)
      d = pack_pose($urandom, $urandom, $urandom, 0, 0, 0, $urandom, $urandom, $urandom);
    else if (kind <= 4) begin
      for (int i = 0; i < IN_DATA_W / 32; i++) d[32*i +: 32] = $urandom;
    end else
      d = pack_pose(rand_signed(1 << 20), rand_signed(1 << 20), rand_signed(1 << 20),
                    fx, fy, fz, rand_signed(1 << 18), rand_signed(1 << 18),
                    rand_signed(1 << 18));
    return d;
  endfunction

  function automatic void fill_projection(output logic [CFG_DATA_W-1:0] v [REG_COUNT],
                                          input int mode);
    for (int i = 0; i < REG_COUNT; i++) begin
      case (mode)
        0: v[i] = {32'(rand_signed(1 << 17)), 32'(rand_signed(1 << 17))};
        1: v[i] = {32'h7FFF_FFFF, 32'h7FFF_FFFF};
        2: v[i] = {32'h8000_0000, 32'h8000_0000};
        default: v[i] = {$urandom, $urandom};
      endcase
    end
  endfunction

  localparam int MAXI = 32'h7FFF_FFFF;
  localparam int MINI = 32'h8000_0000;
  localparam int ONE  = 1 << FB;

  initial begin
    logic [CFG_DATA_W-1:0] pset [REG_COUNT];
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    gap_pct   = 0;
    stall_pct = 0;
    hold_req  = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed poses on the reset projection
    send_pose(pack_pose(0, 0, 0, 0, 0, -ONE, 0, ONE, 0));
    send_pose(pack_pose(ONE, 2 * ONE, 3 * ONE, ONE, 0, 0, 0, ONE, 0));
    send_pose(pack_pose(MAXI, MAXI, MAXI, MAXI, MAXI, MAXI, MINI, 0, MAXI));
    send_pose(pack_pose(MINI, MINI, MINI, MINI, MINI, MINI, MAXI, 0, MINI));
    send_pose(pack_pose(MAXI, MINI, MAXI, 1, 0, 0, 0, 1, 0));
    send_pose(pack_pose(-1, -1, -1, -1, 1, -1, 1, 1, 1));
    // zero facing, zero up, parallel and antiparallel up
    send_pose(pack_pose(ONE, ONE, ONE, 0, 0, 0, 0, ONE, 0));
    send_pose(pack_pose(ONE, ONE, ONE, 0, 0, -ONE, 0, 0, 0));
    send_pose(pack_pose(0, 0, 0, ONE, 2 * ONE, 3 * ONE, 2 * ONE, 4 * ONE, 6 * ONE));
    send_pose(pack_pose(0, 0, 0, MINI, 0, 0, MAXI, 0, 0));
    send_pose(pack_pose(5, -7, 9, MAXI, 1, 0, MAXI, 0, 1));
    send_pose(pack_pose(MAXI, MAXI, MINI, 0, MINI, 0, MINI, MINI, MINI));
    send_pose(pack_pose(1000 * ONE, -1000 * ONE, 0, 3, -4, 5, -ONE, ONE, ONE));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 50; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 50; end
        default: begin gap_pct = 8; stall_pct = 8; end
      endcase
      fill_projection(pset, ph == 3 ? 3 : 0);
      load_projection(pset);
      for (int n = 0; n < 60; n++) begin
        // long receiver hold-off while poses keep coming
        if (ph == 0 && n == 5) hold_req = 1'b1;
        send_pose(random_pose());
      end
      hold_req = 1'b0;
      drain();
    end

    // extreme projections saturate nearly everything
    gap_pct = 8; stall_pct = 8;
    for (int m = 1; m <= 2; m++) begin
      fill_projection(pset, m);
      load_projection(pset);
      for (int n = 0; n < 6; n++) send_pose(random_pose());
      drain();
    end

    if (sb.fails == 0 && sb.owed.size() == 0)
      $display("[look_at_view_projection] OK");
    else
      $display("[look_at_view_projection] ERROR");
    $finish;
  end

  initial begin
    #4000000;
    $display("[look_at_view_projection] ERROR");
    $finish;
  end

endmodule

// ===== look_at_view_projection.f =====
+incdir+rtl
rtl/lavp_pkg.sv
rtl/lavp_norm.sv
rtl/look_at_view_projection.sv
tb/tb_look_at_view_projection.sv
